>>> hdl/rsc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rsc_pkg
// Shared types and constants of the record sorter with exchange count.
// ============================================================================
package rsc_pkg;

    // Width of the exchange total carried with each result; saturates at all ones.
    localparam int SWAP_W = 9;

    // Entries of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // One input request.
    typedef struct packed {
        logic [15:0] sort_key;
        logic [9:0]  marks;
        logic [15:0] name_tag;
        logic        is_final;
    } in_item_t;

    // One result request.
    typedef struct packed {
        logic [15:0]       out_key;
        logic [9:0]        out_marks;
        logic [15:0]       out_tag;
        logic [SWAP_W-1:0] swap_total;
        logic              overflowed;
        logic              out_final;
    } out_item_t;

    // One stored record.
    typedef struct packed {
        logic [15:0] key;
        logic [9:0]  marks;
        logic [15:0] tag;
    } rec_t;

    // Classified request handed from front to back.
    typedef struct packed {
        rec_t rec;
        logic keep;
        logic last;
    } q_item_t;

endpackage

>>> hdl/record_sort_swap_count.sv
`timescale 1ns / 1ps
// Timing: once its final request reaches the back, a batch is sorted in place and then
//   emitted in key order, one result at a time.
// Throughput: one request per cycle while loading; the single-port-write record store and
//   the serial compare-exchange step set the sort time.
// Reset: rst_n asynchronous active low clears counts, flags, queue and sequencer;
//   record store contents are not cleared and need no clearing pass.
// ============================================================================
// record_sort_swap_count
// Batch record sorter: collects records up to the final one, bubble-sorts by
// key (stable, strictly-greater exchange), counts exchanges, emits in order.
// ============================================================================
//
// Structure:
//   rsc_front  - takes input requests, marks each stored or dropped when the
//                store would be full (front keeps its own batch count).
//   rsc_queue  - two-entry FIFO so the front can accept up to two requests while the back
//                is busy, and each side stalls on its own.
//   rsc_back   - record store memory (one write, one registered read port),
//                sort sequencer and output register.
//
// Sort: each pass carries the larger record in a register and writes the
// smaller one back one slot behind, so one read and one write per cycle do a
// full compare-exchange. Each pass ends by writing the carry into its last slot.
module record_sort_swap_count #(
    parameter int MAX_RECORDS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_valid,
    output logic               rec_stall,
    input  rsc_pkg::in_item_t  rec_data,
    output logic               res_valid,
    input  logic               res_stall,
    output rsc_pkg::out_item_t res_data
);

    logic             push;
    logic             q_full;
    rsc_pkg::q_item_t push_item;
    logic             pop;
    logic             q_valid;
    rsc_pkg::q_item_t q_item;

    rsc_front #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec_data  (rec_data),
        .push      (push),
        .q_full    (q_full),
        .push_item (push_item)
    );

    rsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    rsc_back #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

>>> hdl/rsc_front.sv
`timescale 1ns / 1ps
// ============================================================================
// rsc_front
// Accepts input requests and marks each as stored or dropped (store full).
// ============================================================================
module rsc_front #(
    parameter int MAX_RECORDS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_valid,
    output logic               rec_stall,
    input  rsc_pkg::in_item_t  rec_data,
    output logic               push,
    input  logic               q_full,
    output rsc_pkg::q_item_t   push_item
);

    localparam int CW = $clog2(MAX_RECORDS + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          keep;

    assign rec_stall = q_full;
    assign push      = rec_valid && !q_full;
    assign keep      = (count_reg < CW'(MAX_RECORDS));

    assign push_item.rec.key   = rec_data.sort_key;
    assign push_item.rec.marks = rec_data.marks;
    assign push_item.rec.tag   = rec_data.name_tag;
    assign push_item.keep      = keep;
    assign push_item.last      = rec_data.is_final;

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            if (rec_data.is_final)
                count_next = '0;
            else if (keep)
                count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

>>> hdl/rsc_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// rsc_queue
// Small FIFO that decouples the front from the back.
// ============================================================================
module rsc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rsc_pkg::q_item_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output rsc_pkg::q_item_t q_item
);

    localparam int DEPTH = rsc_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    rsc_pkg::q_item_t entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push && !full)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if ((push && !full) && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (!(push && !full) && do_pop)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

>>> hdl/rsc_back.sv
`timescale 1ns / 1ps
// ============================================================================
// rsc_back
// Record store, bubble-sort sequencer with exchange count, and result output.
// ============================================================================
module rsc_back #(
    parameter int MAX_RECORDS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  rsc_pkg::q_item_t   q_item,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_stall,
    output rsc_pkg::out_item_t res_data
);

    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int SW = rsc_pkg::SWAP_W;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS_FIRST,
        ST_PASS_STEP,
        ST_PASS_END,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_HOLD
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      len_reg;
    logic [IW-1:0]      pos_reg;
    logic [IW-1:0]      idx_reg;
    rsc_pkg::rec_t      carry_reg;
    logic [SW-1:0]      swap_reg;
    logic               ovf_reg;
    logic               out_valid_reg;
    rsc_pkg::out_item_t out_item_reg;

    // record store
    rsc_pkg::rec_t      mem [MAX_RECORDS];
    rsc_pkg::rec_t      rdata_reg;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    rsc_pkg::rec_t      wr_data;
    logic [IW-1:0]      rd_addr;

    logic               gt;
    logic [CW-1:0]      batch_n;

    assign gt        = (carry_reg.key > rdata_reg.key);
    assign batch_n   = q_item.keep ? count_reg + CW'(1) : count_reg;
    assign pop       = (state_reg == ST_LOAD) && q_valid;
    assign res_valid = out_valid_reg;
    assign res_data  = out_item_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg - IW'(1);
        wr_data = carry_reg;
        rd_addr = '0;
        case (state_reg)
            ST_LOAD:
            begin
                wr_en   = q_valid && q_item.keep;
                wr_addr = count_reg[IW-1:0];
                wr_data = q_item.rec;
            end
            ST_PASS_FIRST:
                rd_addr = IW'(1);
            ST_PASS_STEP:
            begin
                // the larger record rides along in carry; the smaller drops behind
                wr_en   = 1'b1;
                wr_data = gt ? rdata_reg : carry_reg;
                rd_addr = pos_reg + IW'(1);
            end
            ST_PASS_END:
            begin
                wr_en   = 1'b1;
                wr_addr = IW'(len_reg - CW'(1));
                wr_data = carry_reg;
            end
            ST_EMIT_RD:
                rd_addr = idx_reg;
            ST_EMIT_WAIT:
                rd_addr = idx_reg;
            ST_EMIT_HOLD:
                rd_addr = idx_reg + IW'(1);
            default:
                rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            carry_reg     <= '0;
            swap_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (q_valid)
                    begin
                        count_reg <= batch_n;
                        if (!q_item.keep)
                            ovf_reg <= 1'b1;
                        if (q_item.last)
                        begin
                            len_reg <= batch_n;
                            idx_reg <= '0;
                            if (batch_n >= CW'(2))
                                state_reg <= ST_PASS_FIRST;
                            else
                                state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                ST_PASS_FIRST:
                begin
                    carry_reg <= rdata_reg;
                    pos_reg   <= IW'(1);
                    state_reg <= ST_PASS_STEP;
                end
                ST_PASS_STEP:
                begin
                    if (gt)
                    begin
                        if (swap_reg != {SW{1'b1}})
                            swap_reg <= swap_reg + SW'(1);
                    end
                    else
                        carry_reg <= rdata_reg;
                    if (CW'(pos_reg) == len_reg - CW'(1))
                        state_reg <= ST_PASS_END;
                    else
                        pos_reg <= pos_reg + IW'(1);
                end
                ST_PASS_END:
                begin
                    len_reg <= len_reg - CW'(1);
                    if (len_reg - CW'(1) >= CW'(2))
                        state_reg <= ST_PASS_FIRST;
                    else
                        state_reg <= ST_EMIT_RD;
                end
                ST_EMIT_RD:
                    state_reg <= ST_EMIT_WAIT;
                ST_EMIT_WAIT:
                begin
                    out_item_reg.out_key    <= rdata_reg.key;
                    out_item_reg.out_marks  <= rdata_reg.marks;
                    out_item_reg.out_tag    <= rdata_reg.tag;
                    out_item_reg.swap_total <= swap_reg;
                    out_item_reg.overflowed <= ovf_reg;
                    out_item_reg.out_final  <= (CW'(idx_reg) == count_reg - CW'(1));
                    out_valid_reg           <= 1'b1;
                    state_reg               <= ST_EMIT_HOLD;
                end
                ST_EMIT_HOLD:
                begin
                    if (!res_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_item_reg.out_final)
                        begin
                            count_reg <= '0;
                            swap_reg  <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + IW'(1);
                            state_reg <= ST_EMIT_WAIT;
                        end
                    end
                end
                default:
                    state_reg <= ST_LOAD;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RECORDS))
        else $error("record count above capacity");

    a_pass_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PASS_STEP) |-> (len_reg >= CW'(2) && CW'(pos_reg) < len_reg))
        else $error("sort position outside pass");

    a_swap_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PASS_STEP) |=> (swap_reg >= $past(swap_reg)))
        else $error("exchange count decreased during sort");

    a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_EMIT_HOLD))
        else $error("result shown outside emit");
`endif

endmodule
